// ===== rtl/median_3x3_filter_defines.svh =====
// Assertion macros for the median filter checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef MEDIAN_3X3_FILTER_DEFINES_SVH
`define MEDIAN_3X3_FILTER_DEFINES_SVH

// same-cycle implication
`define MF3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median_3x3_filter: property violated");

// next-cycle implication
`define MF3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median_3x3_filter: property violated");

`endif

// ===== rtl/mf3_pkg.sv =====
// Shared constants, types and register codes of the 3x3 median filter.
// No dependencies.
package mf3_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EW_W       = COL_W + 1;
    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 16;
    localparam int ROW_W      = HCFG_W + 1;
    localparam int IDX_W      = EW_W + HCFG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);
    localparam logic [IDX_W-1:0]  AREA_RESET   = IDX_W'(640 * 480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             border;
        logic             last;
        logic [PIX_W-1:0] sample;
        logic [COL_W-1:0] col;
    } item_t;

    typedef struct packed {
        logic valid;
        logic border;
        logic last;
    } tag_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] filtered;
        logic             frame_end;
    } res_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [IDX_W-1:0] quot;
        logic [COL_W-1:0] rem;
    } div_res_t;

endpackage

// ===== rtl/mf3_if.sv =====
// Stream and configuration interfaces of the 3x3 median filter.
// Depends on mf3_pkg.
interface mf3_in_if
    import mf3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             flush;

    modport source (output valid, pixel, flush, input ready);
    modport sink   (input valid, pixel, flush, output ready);
endinterface

interface mf3_out_if
    import mf3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] filtered;
    logic             frame_end;

    modport source (output valid, filtered, frame_end, input ready);
    modport sink   (input valid, filtered, frame_end, output ready);
endinterface

interface mf3_cfg_if
    import mf3_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mf3_window.sv =====
// Line store memory and 3x3 window register with read-modify-write forwarding.
// Depends on mf3_pkg.
module mf3_window
    import mf3_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  item_t s0,
    output win_t  win,
    output tag_t  tag
);

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    item_t              s1_reg;
    win_t               win_reg;
    tag_t               tag_reg;

    logic [2*PIX_W-1:0] entry;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;

    assign entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign top   = entry[2*PIX_W-1:PIX_W];
    assign mid   = entry[PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv && s0.valid)
        begin
            rd_data_reg <= line_mem[s0.col];
        end
        if (adv && s1_reg.valid)
        begin
            line_mem[s1_reg.col] <= {mid, s1_reg.sample};
        end
        if (adv)
        begin
            fwd_data_reg <= {mid, s1_reg.sample};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg      <= '0;
            fwd_hit_reg <= 1'b0;
            win_reg     <= '0;
            tag_reg     <= '0;
        end
        else if (adv)
        begin
            s1_reg      <= s0;
            fwd_hit_reg <= s0.valid && s1_reg.valid && (s0.col == s1_reg.col);
            tag_reg.valid  <= s1_reg.valid && s1_reg.emit;
            tag_reg.border <= s1_reg.border;
            tag_reg.last   <= s1_reg.last;
            if (s1_reg.valid)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= top;
                win_reg[1][2] <= mid;
                win_reg[2][2] <= s1_reg.sample;
            end
        end
    end

    assign win = win_reg;
    assign tag = tag_reg;

endmodule

// ===== rtl/mf3_median.sv =====
// Two-step median of the 3x3 window: column sort, then merge of sorted columns.
// Depends on mf3_pkg.
module mf3_median
    import mf3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  win_t win,
    input  tag_t tag,
    output res_t res
);

    typedef struct packed {
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] md;
        logic [PIX_W-1:0] lo;
    } trio_t;

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic trio_t sort3(input logic [PIX_W-1:0] a,
                                    input logic [PIX_W-1:0] b,
                                    input logic [PIX_W-1:0] c);
        trio_t t;
        t.lo = min2(min2(a, b), c);
        t.hi = max2(max2(a, b), c);
        t.md = med3(a, b, c);
        return t;
    endfunction

    trio_t [2:0]      col_reg;
    logic [PIX_W-1:0] center_reg;
    tag_t             tag_reg;

    logic [PIX_W-1:0] lo_max;
    logic [PIX_W-1:0] md_med;
    logic [PIX_W-1:0] hi_min;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                col_reg[j] <= sort3(win[0][j], win[1][j], win[2][j]);
            end
            center_reg <= win[1][1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (adv)
        begin
            tag_reg <= tag;
        end
    end

    always_comb
    begin
        lo_max = max2(max2(col_reg[0].lo, col_reg[1].lo), col_reg[2].lo);
        md_med = med3(col_reg[0].md, col_reg[1].md, col_reg[2].md);
        hi_min = min2(min2(col_reg[0].hi, col_reg[1].hi), col_reg[2].hi);
        res.valid     = tag_reg.valid;
        res.frame_end = tag_reg.last;
        res.filtered  = tag_reg.border ? center_reg : med3(lo_max, md_med, hi_min);
    end

endmodule

// ===== rtl/mf3_div.sv =====
// Restoring divider that rebuilds the output row and column after a register write.
// Depends on mf3_pkg.
module mf3_div
    import mf3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [EW_W-1:0]  divisor,
    output div_res_t         res
);

    localparam int CNT_W = $clog2(IDX_W);

    logic             active_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [EW_W-1:0]  rem_reg;
    logic [IDX_W-1:0] quo_reg;

    logic [EW_W:0]    trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[IDX_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            rem_reg    <= '0;
            quo_reg    <= dividend;
        end
        else
        begin
            done_reg <= 1'b0;
            if (active_reg)
            begin
                rem_reg   <= fits ? EW_W'(trial - {1'b0, divisor}) : trial[EW_W-1:0];
                quo_reg   <= {quo_reg[IDX_W-2:0], fits};
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(IDX_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    assign res.busy = active_reg;
    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg[COL_W-1:0];

endmodule

// ===== rtl/median_3x3_filter.sv =====
// Top level of the 3x3 median filter: registers, position counters, output register.
// Depends on mf3_pkg, mf3_if, mf3_window, mf3_median and mf3_div.
//
// Usage:
//   pixels  - sink of 8-bit samples plus a flush flag, raster order.
//   results - source of filtered samples plus frame_end on the last one.
//   cfg     - register writes: index 0 frame_width, index 1 frame_height.
// One word is taken per clock when results is not stalled and no register
// write is being processed. The result for an item passes the window stage,
// window, column sort and output registers; the result stream itself lags
// the input by width+1 items, and width+1 flush words drain the end of a
// frame. A frame_end result restarts all counters. The output register frees
// the input side: a new word is taken in the same cycle a waiting result is
// taken. If results stalls, the whole pipeline holds and pixels.ready drops.
// After any register write, pixels.ready stays low while a bit-serial
// divider rebuilds the output row and column (one quotient bit per cycle
// over the 27-bit pixel count).
// Reset clears counters and the window to zero and loads 640 x 480.
// The line stores hold no reset value.
module median_3x3_filter
    import mf3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mf3_cfg_if.sink    cfg,
    mf3_in_if.sink     pixels,
    mf3_out_if.source  results
);

    logic [WCFG_W-1:0] width_cfg_reg;
    logic [HCFG_W-1:0] height_cfg_reg;
    logic              cfg_pend_reg;
    logic [IDX_W-1:0]  area_reg;
    logic [IDX_W-1:0]  area_m1_reg;

    logic [COL_W-1:0]  in_column_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [IDX_W-1:0]  out_row_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  filtered_reg;
    logic              frame_end_reg;

    logic [EW_W-1:0]   eff_w;
    logic [HCFG_W-1:0] eff_h;
    logic [COL_W-1:0]  col;
    logic [EW_W-1:0]   col_inc;
    logic              wrap;
    logic              emit;
    logic              border;
    logic              last;
    logic              adv;
    logic              busy;
    logic              accept;
    item_t             s0;
    win_t              win;
    tag_t              tag;
    res_t              med;
    div_res_t          div;

    always_comb
    begin
        if (width_cfg_reg < WCFG_W'(3))
        begin
            eff_w = EW_W'(3);
        end
        else if (width_cfg_reg > WCFG_W'(MAX_WIDTH))
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(width_cfg_reg);
        end
        eff_h = (height_cfg_reg < HCFG_W'(3)) ? HCFG_W'(3) : height_cfg_reg;
    end

    assign adv    = !out_valid_reg || results.ready;
    assign busy   = cfg_pend_reg || div.busy || div.done;
    assign accept = pixels.valid && pixels.ready;

    assign pixels.ready = adv && !busy;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        col     = ({1'b0, in_column_reg} < eff_w) ? in_column_reg
                                                  : COL_W'(eff_w - 1'b1);
        col_inc = {1'b0, col} + 1'b1;
        wrap    = col_inc >= eff_w;
        emit    = (in_row_reg >= ROW_W'(2)) || ((in_row_reg == ROW_W'(1)) && (col != '0));
        border  = (out_row_reg == '0)
               || (out_row_reg >= IDX_W'(eff_h - 1'b1))
               || (out_col_reg == '0)
               || ({1'b0, out_col_reg} >= EW_W'(eff_w - 1'b1));
        last    = out_index_reg >= area_m1_reg;

        s0.valid  = accept;
        s0.emit   = emit;
        s0.border = border;
        s0.last   = last;
        s0.sample = pixels.flush ? '0 : pixels.pixel;
        s0.col    = col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            cfg_pend_reg   <= 1'b0;
            area_reg       <= AREA_RESET;
            area_m1_reg    <= AREA_RESET - 1'b1;
        end
        else
        begin
            area_reg     <= IDX_W'(eff_w) * IDX_W'(eff_h);
            area_m1_reg  <= area_reg - 1'b1;
            cfg_pend_reg <= cfg.valid && cfg.ready;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    CFG_FRAME_WIDTH:  width_cfg_reg  <= cfg.data[WCFG_W-1:0];
                    CFG_FRAME_HEIGHT: height_cfg_reg <= cfg.data[HCFG_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
            out_index_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
        end
        else if (div.done)
        begin
            out_col_reg <= div.rem;
            out_row_reg <= div.quot;
        end
        else if (accept)
        begin
            if (emit && last)
            begin
                in_column_reg <= '0;
                in_row_reg    <= '0;
                out_index_reg <= '0;
                out_col_reg   <= '0;
                out_row_reg   <= '0;
            end
            else
            begin
                in_column_reg <= wrap ? '0 : col_inc[COL_W-1:0];
                if (wrap && (in_row_reg < ({1'b0, eff_h} + 1'b1)))
                begin
                    in_row_reg <= in_row_reg + 1'b1;
                end
                if (emit)
                begin
                    out_index_reg <= out_index_reg + 1'b1;
                    if ({1'b0, out_col_reg} >= EW_W'(eff_w - 1'b1))
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    mf3_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .s0    (s0),
        .win   (win),
        .tag   (tag)
    );

    mf3_median u_median (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .win   (win),
        .tag   (tag),
        .res   (med)
    );

    mf3_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_pend_reg),
        .dividend (out_index_reg),
        .divisor  (eff_w),
        .res      (div)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= med.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && med.valid)
        begin
            filtered_reg  <= med.filtered;
            frame_end_reg <= med.frame_end;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.filtered  = filtered_reg;
    assign results.frame_end = frame_end_reg;

endmodule

// ===== rtl/mf3_props.sv =====
// Port-level assertions of the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and median_3x3_filter_defines.svh.
`include "median_3x3_filter_defines.svh"

module mf3_props
    import mf3_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] out_filtered,
    input logic             out_frame_end,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    // a stalled result holds its word
    `MF3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_filtered) && $stable(out_frame_end))

    // input is taken only when the output register can move
    `MF3_ASSERT_NOW(a_ready_needs_room, in_ready, !out_valid || out_ready)

    // a register write blocks the input while positions are rebuilt
    `MF3_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !in_ready && !in_valid || !in_ready)

    // input never taken in the cycle a write lands
    `MF3_ASSERT_NOW(a_no_input_on_write, $past(cfg_valid && cfg_ready), !(in_valid && in_ready))

endmodule

bind median_3x3_filter mf3_props u_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixels.valid),
    .in_ready      (pixels.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_filtered  (results.filtered),
    .out_frame_end (results.frame_end),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready)
);

// ===== bench/tb_median_3x3_filter.sv =====
`timescale 1ns / 100ps
// Self-checking bench for median_3x3_filter: drives pixel frames and register writes,
// predicts every filtered word and compares it field by field on the result stream.
// Depends on mf3_pkg, the mf3 interfaces and the filter RTL.
module tb_median_3x3_filter;
    import mf3_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1350;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned REPORT_LIMIT  = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        TEX_NOISE,
        TEX_SMOOTH,
        TEX_SPECKLE
    } texture_t;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             frame_end;
    } pixel_result_t;

    class median_scoreboard;
        logic [WCFG_W-1:0] width_reg;
        logic [HCFG_W-1:0] height_reg;
        logic [PIX_W-1:0]  upper_row [MAX_WIDTH];
        logic [PIX_W-1:0]  middle_row [MAX_WIDTH];
        logic [PIX_W-1:0]  win [3][3];
        int unsigned       in_col;
        int unsigned       in_row;
        int unsigned       out_idx;
        pixel_result_t     filtered_q [$];
        int unsigned       errors;
        int unsigned       median_count;
        int unsigned       border_count;
        int unsigned       frames_closed;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win[r][c] = '0;
                end
            end
            in_col        = 0;
            in_row        = 0;
            out_idx       = 0;
            errors        = 0;
            median_count  = 0;
            border_count  = 0;
            frames_closed = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_FRAME_WIDTH)
                width_reg = data[WCFG_W-1:0];
            else if (index == CFG_FRAME_HEIGHT)
                height_reg = data[HCFG_W-1:0];
        endfunction

        function int unsigned eff_width();
            if (width_reg < 3)
                return 3;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg < 3) ? 3 : height_reg;
        endfunction

        function bit frame_open();
            return (in_col != 0) || (in_row != 0) || (out_idx != 0);
        endfunction

        function int unsigned pending();
            return filtered_q.size();
        endfunction

        function logic [PIX_W-1:0] median_of_window();
            logic [PIX_W-1:0] v [9];
            logic [PIX_W-1:0] t;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    v[r * 3 + c] = win[r][c];
                end
            end
            for (int i = 0; i < 8; i++)
            begin
                for (int j = 0; j < 8 - i; j++)
                begin
                    if (v[j] > v[j + 1])
                    begin
                        t        = v[j];
                        v[j]     = v[j + 1];
                        v[j + 1] = t;
                    end
                end
            end
            return v[4];
        endfunction

        function void take_pixel(logic [PIX_W-1:0] pixel, logic flush);
            int unsigned      w;
            int unsigned      h;
            int unsigned      c;
            int unsigned      orow;
            int unsigned      ocol;
            logic [PIX_W-1:0] sample;
            logic [PIX_W-1:0] top;
            logic [PIX_W-1:0] mid;
            bit               emit;
            bit               border;
            pixel_result_t    res;
            w      = eff_width();
            h      = eff_height();
            sample = flush ? '0 : pixel;
            c      = (in_col < w) ? in_col : w - 1;
            emit   = (in_row >= 2) || (in_row == 1 && c >= 1);
            top    = upper_row[c];
            mid    = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = sample;
            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = sample;
            c++;
            if (c >= w)
            begin
                c = 0;
                if (in_row < h + 1)
                    in_row++;
            end
            in_col = c;
            if (!emit)
                return;
            orow   = out_idx / w;
            ocol   = out_idx % w;
            border = (orow == 0) || (orow >= h - 1) || (ocol == 0) || (ocol >= w - 1);
            res.filtered  = border ? win[1][1] : median_of_window();
            res.frame_end = (out_idx >= w * h - 1);
            if (border)
                border_count++;
            else
                median_count++;
            filtered_q.push_back(res);
            if (res.frame_end)
            begin
                in_col  = 0;
                in_row  = 0;
                out_idx = 0;
                frames_closed++;
            end
            else
            begin
                out_idx++;
            end
        endfunction

        function void note_error();
            errors++;
        endfunction

        function void check_pixel(logic [PIX_W-1:0] filtered, logic frame_end);
            pixel_result_t want;
            if (filtered_q.size() == 0)
            begin
                if (errors < REPORT_LIMIT)
                    $error("unexpected word: filtered %0d, frame_end %0b", filtered, frame_end);
                errors++;
                return;
            end
            want = filtered_q.pop_front();
            if (filtered !== want.filtered)
            begin
                if (errors < REPORT_LIMIT)
                    $error("filtered: expected %0d, actual %0d", want.filtered, filtered);
                errors++;
            end
            if (frame_end !== want.frame_end)
            begin
                if (errors < REPORT_LIMIT)
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mf3_cfg_if cfg_if ();
    mf3_in_if  pix_if ();
    mf3_out_if res_if ();

    median_3x3_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .pixels  (pix_if),
        .results (res_if)
    );

    median_scoreboard sb = new();

    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned random_items = 0;
    int unsigned settings     = 0;
    int unsigned stuck        = 0;

    logic [PIX_W-1:0] directed_pixels [16] = '{
        8'h00, 8'hFF, 8'h80, 8'h7F,
        8'hFF, 8'h01, 8'hFE, 8'h00,
        8'h55, 8'hAA, 8'hFF, 8'hFF,
        8'h10, 8'hEF, 8'h33, 8'hCC
    };
    logic [15:0] directed_flush = 16'h0400;
    logic [7:0]  drain_live     = 8'b0000_0100;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned idle_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(texture_t texture, int unsigned base);
        case (texture)
            TEX_SMOOTH:
                return PIX_W'(base + $urandom_range(0, 15));
            TEX_SPECKLE:
                case ($urandom_range(0, 7))
                    0:       return '0;
                    1:       return '1;
                    default: return PIX_W'(base);
                endcase
            default:
                return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic [PIX_W-1:0] pixel, input logic flush);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= pixel;
        pix_if.flush <= flush;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        sb.take_pixel(pixel, flush);
        random_items++;
    endtask

    task automatic wait_results_clear();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_results_clear();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.set_reg(index, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height);
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
        cfg_if.valid <= 1'b0;
        settings++;
    endtask

    task automatic send_frame(input texture_t texture, input bit truncate, input bit noisy);
        int unsigned n;
        int unsigned base;
        n    = sb.eff_width() * sb.eff_height();
        base = $urandom_range(0, 240);
        if (truncate)
            n = $urandom_range(1, n - 1);
        for (int unsigned i = 0; i < n; i++)
        begin
            send_item(pick_pixel(texture, base), $urandom_range(0, 99) < 2);
        end
        // drain until the frame closes; noisy drains carry live samples
        while (sb.frame_open())
        begin
            send_item(PIX_W'($urandom_range(0, 255)), !(noisy && $urandom_range(0, 3) == 0));
        end
    endtask

    initial
    begin
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        pix_if.flush <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_FRAME_WIDTH;
        cfg_if.data  <= '0;
    end

    initial
    begin : result_sink
        int unsigned stall;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = idle_gap();
                res_if.ready <= (stall == 0);
                repeat ((stall == 0) ? $urandom_range(1, 8) : stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_pixel(res_if.filtered, res_if.frame_end);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
        begin
            stuck <= 0;
        end
        else if (stuck >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stuck <= stuck + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frame: extremes, a flush inside the frame, a live sample in the drain
        configure(16'd4, 16'd4);
        for (int i = 0; i < 16; i++)
        begin
            send_item(directed_pixels[i], directed_flush[i]);
            if (i == 7)
                wait_results_clear();
        end
        for (int j = 0; sb.frame_open(); j++)
        begin
            send_item(8'hA5, !(j < 8 && drain_live[j]));
        end
        settle();

        // hold the result side while the pixel side keeps offering words
        configure(16'd24, 16'd12);
        calm     = 1'b1;
        hold_req = 1'b1;
        send_frame(TEX_NOISE, 1'b0, 1'b0);
        calm = 1'b0;
        settle();

        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9)) inside
                0:       configure(CFG_DATA_W'($urandom_range(0, 2)),
                                   CFG_DATA_W'($urandom_range(3, 8)));
                1:       configure(16'hF800 | CFG_DATA_W'($urandom_range(3, 12)),
                                   CFG_DATA_W'($urandom_range(0, 2)));
                [2:3]:   configure(CFG_DATA_W'($urandom_range(13, 64)),
                                   CFG_DATA_W'($urandom_range(3, 5)));
                default: configure(CFG_DATA_W'($urandom_range(3, 12)),
                                   CFG_DATA_W'($urandom_range(3, 8)));
            endcase
            repeat ($urandom_range(1, 3))
            begin
                calm = ($urandom_range(0, 3) == 0);
                send_frame(texture_t'($urandom_range(0, 2)), $urandom_range(0, 9) == 0,
                           $urandom_range(0, 4) == 0);
            end
            calm = 1'b0;
            settle();
        end

        // unused register index, then zero sizes that clamp to the smallest frame
        write_reg(CFG_SPARE, 16'hFFFF);
        configure(16'd0, 16'd0);
        send_frame(TEX_SPECKLE, 1'b0, 1'b1);
        settle();

        if (sb.pending() != 0)
        begin
            $error("%0d filtered words never arrived", sb.pending());
            sb.note_error();
        end
        $display("Sent %0d pixel words in %0d frames over %0d register settings,",
                 random_items, sb.frames_closed, settings);
        $display("checking %0d interior medians and %0d border words.",
                 sb.median_count, sb.border_count);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_if.sv
rtl/mf3_window.sv
rtl/mf3_median.sv
rtl/mf3_div.sv
rtl/median_3x3_filter.sv
rtl/mf3_props.sv
bench/tb_median_3x3_filter.sv
